/* rtl/dit_pkg.sv */
// Package for the duplicate ID tracker: table sizes, command codes and the
// per-cell control struct. Used by every module in rtl/.
`timescale 1ns / 1ps
package dit_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int ID_WIDTH    = 32;
  localparam int IN_ID_W     = 32;
  localparam int OUT_CNT_W   = 5;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam logic CMD_REQUEST  = 1'b0;
  localparam logic CMD_COMPLETE = 1'b1;

  typedef logic [ID_WIDTH-1:0]    id_t;
  typedef logic [TABLE_DEPTH-1:0] row_t;
  typedef logic [CNT_W-1:0]       cnt_t;

  // One bit per cell for each operation applied at the update edge.
  typedef struct packed {
    row_t shift;
    row_t load;
    row_t mark;
  } cell_cmd_t;

endpackage

/* rtl/dit_cell.sv */
// One table cell: an ID, its duplicate mark and a valid bit.
// Takes its neighbor's contents on a shift. Depends on dit_pkg.
`timescale 1ns / 1ps
module dit_cell (
  input  logic          clk,
  input  logic          rst,
  input  logic          shift,
  input  logic          load,
  input  logic          mark,
  input  dit_pkg::id_t  key,
  input  dit_pkg::id_t  nb_id,
  input  logic          nb_marked,
  input  logic          nb_valid,
  output dit_pkg::id_t  id,
  output logic          marked,
  output logic          valid,
  output logic          hit
);
  import dit_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= 1'b0;
      marked <= 1'b0;
    end else if (shift) begin
      valid  <= nb_valid;
      marked <= nb_marked;
    end else if (load) begin
      valid  <= 1'b1;
      marked <= 1'b0;
    end else if (mark) begin
      marked <= 1'b1;
    end
  end

  // The ID needs no reset; it is only looked at while valid is set.
  always_ff @(posedge clk) begin
    if (shift) begin
      id <= nb_id;
    end else if (load) begin
      id <= key;
    end
  end

  assign hit = valid && (id == key);

endmodule

/* rtl/dit_ctrl.sv */
// Sequencer for the duplicate ID tracker: picks the matching cell, drives
// the cell operations, keeps the entry count and registers the result.
// Depends on dit_pkg.
`timescale 1ns / 1ps
module dit_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic                      cmd,
  input  dit_pkg::row_t             hit_vec,
  input  dit_pkg::row_t             marked_vec,
  output logic                      busy,
  output dit_pkg::cell_cmd_t        cell_cmd,
  output dit_pkg::cnt_t             count,
  output logic                      done,
  output logic                      send_response,
  output logic                      was_duplicate,
  output logic                      not_found,
  output logic                      earlier_match,
  output logic                      table_full,
  output logic [dit_pkg::OUT_CNT_W-1:0] outstanding
);
  import dit_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SEARCH = 2'd1;
  localparam logic [1:0] ST_APPLY  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       cmd_q;
  row_t       sel;
  logic       found;
  logic       sel_marked;
  logic       accept;
  logic       is_full;
  row_t       pick;
  row_t       load_dec;
  cnt_t       count_next;

  function automatic row_t reverse_row(input row_t v);
    row_t r;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      r[i] = v[TABLE_DEPTH-1-i];
    end
    return r;
  endfunction

  function automatic row_t lowest_bit(input row_t v);
    return v & (~v + 1'b1);
  endfunction

  assign busy    = (state == ST_SEARCH);
  assign accept  = start && !busy;
  assign is_full = (count == cnt_t'(TABLE_DEPTH));

  // A request marks the oldest match; a completion removes the newest.
  always_comb begin
    if (cmd_q == CMD_REQUEST) begin
      pick = lowest_bit(hit_vec);
    end else begin
      pick = reverse_row(lowest_bit(reverse_row(hit_vec)));
    end
  end

  always_comb begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      load_dec[i] = (count == cnt_t'(i));
    end
  end

  always_comb begin
    cell_cmd = '0;
    if (state == ST_APPLY) begin
      if (cmd_q == CMD_REQUEST) begin
        cell_cmd.mark = sel;
        cell_cmd.load = is_full ? '0 : load_dec;
      end else if (found) begin
        // Every cell at or above the removed one takes its neighbor's entry.
        cell_cmd.shift = ~(sel - 1'b1);
      end
    end
  end

  always_comb begin
    count_next = count;
    if (cmd_q == CMD_REQUEST) begin
      if (!is_full) begin
        count_next = count + 1'b1;
      end
    end else if (found) begin
      count_next = count - 1'b1;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   state_next = accept ? ST_SEARCH : ST_IDLE;
      ST_SEARCH: state_next = ST_APPLY;
      ST_APPLY:  state_next = accept ? ST_SEARCH : ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == ST_APPLY);
      if (state == ST_APPLY) begin
        count <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q <= cmd;
    end
    if (state == ST_SEARCH) begin
      sel        <= pick;
      found      <= |hit_vec;
      sel_marked <= |(pick & marked_vec);
    end
    if (state == ST_APPLY) begin
      outstanding <= OUT_CNT_W'(count_next);
      if (cmd_q == CMD_REQUEST) begin
        send_response <= 1'b0;
        was_duplicate <= 1'b0;
        not_found     <= 1'b0;
        earlier_match <= found;
        table_full    <= is_full;
      end else begin
        send_response <= !(found && sel_marked);
        was_duplicate <= found && sel_marked;
        not_found     <= !found;
        earlier_match <= 1'b0;
        table_full    <= 1'b0;
      end
    end
  end

endmodule

/* rtl/duplicate_id_tracker.sv */
// An accepted item passes through a search state, the parallel compare across
// the cell row, then an apply state that does the mark, append or shift-down
// and registers the result, which done then strobes.
// A new item may be accepted in the cycle the previous result is applied.
// Reset (rst, synchronous) empties the table at once; no clearing pass.
// Results are strobed on done for one cycle and cannot be held off.
`timescale 1ns / 1ps
module duplicate_id_tracker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic                              cmd,
  input  logic [dit_pkg::IN_ID_W-1:0]       completion_id,
  output logic                              busy,
  output logic                              done,
  output logic                              send_response,
  output logic                              was_duplicate,
  output logic                              not_found,
  output logic                              earlier_match,
  output logic                              table_full,
  output logic [dit_pkg::OUT_CNT_W-1:0]     outstanding
);
  import dit_pkg::*;

  id_t       key;
  row_t      hit_vec;
  row_t      marked_vec;
  row_t      valid_vec;
  id_t       id_arr [TABLE_DEPTH];
  cell_cmd_t cell_cmd;
  cnt_t      count;

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      key <= ID_WIDTH'(completion_id);
    end
  end

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    id_t  nb_id;
    logic nb_marked;
    logic nb_valid;

    if (i == TABLE_DEPTH - 1) begin : g_top
      assign nb_id     = '0;
      assign nb_marked = 1'b0;
      assign nb_valid  = 1'b0;
    end else begin : g_mid
      assign nb_id     = id_arr[i+1];
      assign nb_marked = marked_vec[i+1];
      assign nb_valid  = valid_vec[i+1];
    end

    dit_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .shift     (cell_cmd.shift[i]),
      .load      (cell_cmd.load[i]),
      .mark      (cell_cmd.mark[i]),
      .key       (key),
      .nb_id     (nb_id),
      .nb_marked (nb_marked),
      .nb_valid  (nb_valid),
      .id        (id_arr[i]),
      .marked    (marked_vec[i]),
      .valid     (valid_vec[i]),
      .hit       (hit_vec[i])
    );
  end

  dit_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .cmd           (cmd),
    .hit_vec       (hit_vec),
    .marked_vec    (marked_vec),
    .busy          (busy),
    .cell_cmd      (cell_cmd),
    .count         (count),
    .done          (done),
    .send_response (send_response),
    .was_duplicate (was_duplicate),
    .not_found     (not_found),
    .earlier_match (earlier_match),
    .table_full    (table_full),
    .outstanding   (outstanding)
  );

  // The valid cells always form a solid block at the old end of the row.
  a_valid_packed: assert property (@(posedge clk) disable iff (rst)
    (valid_vec & (valid_vec + 1'b1)) == '0)
    else $error("valid cells are not packed at the old end");

  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    $countones(valid_vec) == int'(count))
    else $error("entry count disagrees with valid cells");

  a_done_after_search: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy, 2))
    else $error("result strobed without a preceding search");

  a_single_search: assert property (@(posedge clk) disable iff (rst)
    busy |=> !busy)
    else $error("search lasted more than one cycle");

  a_dup_suppresses: assert property (@(posedge clk) disable iff (rst)
    done |-> !(send_response && was_duplicate))
    else $error("response sent for a duplicate entry");

endmodule

/* bench/dit_checker.sv */
// Checker for the duplicate ID tracker: watches the command and result ports,
// keeps its own copy of the ID table and compares every result it sees.
// Depends on dit_pkg from rtl/.
`timescale 1ns / 1ps
module dit_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          busy,
  input  logic                          cmd,
  input  logic [dit_pkg::IN_ID_W-1:0]   completion_id,
  input  logic                          done,
  input  logic                          send_response,
  input  logic                          was_duplicate,
  input  logic                          not_found,
  input  logic                          earlier_match,
  input  logic                          table_full,
  input  logic [dit_pkg::OUT_CNT_W-1:0] outstanding,
  output int                            fail_count,
  output int                            pending,
  output int                            results_seen,
  output int                            dup_seen,
  output int                            full_seen,
  output int                            nf_seen
);
  import dit_pkg::*;

  typedef struct packed {
    logic                 send;
    logic                 dup;
    logic                 nf;
    logic                 early;
    logic                 full;
    logic [OUT_CNT_W-1:0] held;
  } outcome_t;

  id_t      held_id[TABLE_DEPTH];
  logic     held_mark[TABLE_DEPTH];
  int       held_count = 0;
  outcome_t outcome_q[$];
  outcome_t want;
  int       errs = 0;
  int       n_results = 0;
  int       n_dup = 0;
  int       n_full = 0;
  int       n_nf = 0;

  assign fail_count   = errs;
  assign pending      = outcome_q.size();
  assign results_seen = n_results;
  assign dup_seen     = n_dup;
  assign full_seen    = n_full;
  assign nf_seen      = n_nf;

  // Applies one item to the shadow table and returns what the block should report.
  function automatic outcome_t track_item(logic op, id_t id);
    outcome_t r;
    int       pos;
    r   = '0;
    pos = -1;
    if (op == CMD_REQUEST) begin
      for (int i = 0; i < held_count; i++)
        if (pos < 0 && held_id[i] == id) pos = i;
      if (pos >= 0) begin
        held_mark[pos] = 1'b1;
        r.early = 1'b1;
      end
      if (held_count < TABLE_DEPTH) begin
        held_id[held_count]   = id;
        held_mark[held_count] = 1'b0;
        held_count++;
      end else begin
        r.full = 1'b1;
      end
    end else begin
      for (int i = held_count - 1; i >= 0; i--)
        if (pos < 0 && held_id[i] == id) pos = i;
      if (pos >= 0) begin
        r.dup  = held_mark[pos];
        r.send = !held_mark[pos];
        for (int i = pos; i < held_count - 1; i++) begin
          held_id[i]   = held_id[i + 1];
          held_mark[i] = held_mark[i + 1];
        end
        held_count--;
        held_mark[held_count] = 1'b0;
      end else begin
        r.send = 1'b1;
        r.nf   = 1'b1;
      end
    end
    r.held = OUT_CNT_W'(held_count);
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t ns: MISMATCH %s", $time, msg);
    errs++;
  endtask

  task automatic check_field(string name, int got, int exp);
    if (got != exp)
      report_mismatch($sformatf("%s got %0d expected %0d", name, got, exp));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      held_count = 0;
      for (int i = 0; i < TABLE_DEPTH; i++) held_mark[i] = 1'b0;
      outcome_q.delete();
    end else begin
      // Results leave before the new item is predicted; order stays correct
      // even if both happen at one edge.
      if (done) begin
        if (outcome_q.size() == 0) begin
          report_mismatch("result strobed with no item outstanding");
        end else begin
          want = outcome_q.pop_front();
          n_results++;
          check_field("send_response", send_response, want.send);
          check_field("was_duplicate", was_duplicate, want.dup);
          check_field("not_found", not_found, want.nf);
          check_field("earlier_match", earlier_match, want.early);
          check_field("table_full", table_full, want.full);
          check_field("outstanding", outstanding, want.held);
          if (want.dup) n_dup++;
          if (want.full) n_full++;
          if (want.nf) n_nf++;
        end
      end
      if (start && !busy)
        outcome_q.push_back(track_item(cmd, id_t'(completion_id)));
    end
  end

endmodule

/* bench/tb.sv */
// Top of the duplicate ID tracker bench: clock, reset, directed and random
// command stimulus, and the final verdict. Depends on dit_pkg, the
// duplicate_id_tracker RTL and bench/dit_checker.sv.
`timescale 1ns / 1ps
module tb;
  import dit_pkg::*;

  logic                 clk;
  logic                 rst;
  logic                 start;
  logic                 cmd;
  logic [IN_ID_W-1:0]   completion_id;
  logic                 busy;
  logic                 done;
  logic                 send_response;
  logic                 was_duplicate;
  logic                 not_found;
  logic                 earlier_match;
  logic                 table_full;
  logic [OUT_CNT_W-1:0] outstanding;
  int                   fail_count;
  int                   pending;
  int                   results_seen;
  int                   dup_seen;
  int                   full_seen;
  int                   nf_seen;

  logic [IN_ID_W-1:0] id_pool[6];

  duplicate_id_tracker i_dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .cmd           (cmd),
    .completion_id (completion_id),
    .busy          (busy),
    .done          (done),
    .send_response (send_response),
    .was_duplicate (was_duplicate),
    .not_found     (not_found),
    .earlier_match (earlier_match),
    .table_full    (table_full),
    .outstanding   (outstanding)
  );

  dit_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .cmd           (cmd),
    .completion_id (completion_id),
    .done          (done),
    .send_response (send_response),
    .was_duplicate (was_duplicate),
    .not_found     (not_found),
    .earlier_match (earlier_match),
    .table_full    (table_full),
    .outstanding   (outstanding),
    .fail_count    (fail_count),
    .pending       (pending),
    .results_seen  (results_seen),
    .dup_seen      (dup_seen),
    .full_seen     (full_seen),
    .nf_seen       (nf_seen)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Presents one item and returns at the edge that accepts it.
  task automatic issue(input logic op, input logic [IN_ID_W-1:0] id);
    start         <= 1'b1;
    cmd           <= op;
    completion_id <= id;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Idle with start low and fresh junk on the payload at each edge; n must be at least one.
  task automatic rest(input int n);
    start <= 1'b0;
    repeat (n) begin
      cmd           <= 1'($urandom);
      completion_id <= $urandom;
      @(posedge clk);
    end
  endtask

  task automatic drain_wait();
    start <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  function automatic logic [IN_ID_W-1:0] pick_id();
    if ($urandom_range(0, 9) < 7) return id_pool[$urandom_range(0, 5)];
    return $urandom;
  endfunction

  initial begin
    int req_pct;
    int left;
    int burst;
    int guard;
    rst           = 1'b1;
    start         = 1'b0;
    cmd           = CMD_REQUEST;
    completion_id = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: completion on an empty table, repeated IDs at both extremes,
    // a request whose oldest match is already marked, then a full table.
    issue(CMD_COMPLETE, 32'h0000_0000);
    issue(CMD_REQUEST, 32'h0000_0000);
    issue(CMD_REQUEST, 32'hFFFF_FFFF);
    issue(CMD_REQUEST, 32'h0000_0000);
    issue(CMD_REQUEST, 32'h0000_0000);
    issue(CMD_COMPLETE, 32'h0000_0000);
    issue(CMD_COMPLETE, 32'h0000_0000);
    issue(CMD_COMPLETE, 32'h0000_0000);
    issue(CMD_COMPLETE, 32'hFFFF_FFFF);
    issue(CMD_COMPLETE, 32'h0000_0000);
    for (int i = 1; i <= TABLE_DEPTH; i++) issue(CMD_REQUEST, IN_ID_W'(i));
    issue(CMD_REQUEST, 32'd5);
    issue(CMD_COMPLETE, 32'd5);
    drain_wait();

    // Random phases alternate between filling, draining and a mix, with a
    // small ID pool so that matches and duplicates are frequent.
    for (int ph = 0; ph < 9; ph++) begin
      for (int k = 0; k < 6; k++) id_pool[k] = $urandom;
      if ($urandom_range(0, 1) == 0) id_pool[0] = '0;
      if ($urandom_range(0, 1) == 0) id_pool[5] = '1;
      req_pct = (ph % 3 == 0) ? 75 : (ph % 3 == 1) ? 25 : 50;
      left = 50;
      while (left > 0) begin
        burst = $urandom_range(1, 16);
        if (burst > left) burst = left;
        repeat (burst) begin
          issue(($urandom_range(0, 99) < req_pct) ? CMD_REQUEST : CMD_COMPLETE, pick_id());
        end
        left -= burst;
        if ($urandom_range(0, 3) != 0) rest($urandom_range(1, 6));
      end
      if (ph % 2 == 0) drain_wait();
    end
    start <= 1'b0;

    guard = 0;
    while (pending != 0 && guard < 1000) begin
      @(negedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);
    if (pending != 0) $display("%0d results never arrived", pending);
    $display("Checked %0d results over directed and random command mixes.", results_seen);
    $display("Seen %0d suppressed duplicates, %0d full-table drops, %0d unmatched completions.",
             dup_seen, full_seen, nf_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("** duplicate_id_tracker: PASSED **");
    end else begin
      $display("** duplicate_id_tracker: FAILED **");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timeout: run did not finish.");
    $display("** duplicate_id_tracker: FAILED **");
    $finish;
  end

endmodule
